/* src/wcw_pkg.sv */
// Shared types, constants and bitmap ROM contents for the wide character width classifier.
package wcw_pkg;

    // Field widths.
    localparam int CP_W   = 21;
    localparam int IDX_W  = 12;
    localparam int WORD_W = 32;
    localparam int SEL_W  = 5;

    // Range bases and ROM offsets.
    localparam logic [CP_W-1:0] STD_BASE_A = 21'h002E80;
    localparam logic [CP_W-1:0] STD_BASE_B = 21'h00FE10;
    localparam logic [CP_W-1:0] STD_OFF_B  = 21'd448;
    localparam logic [CP_W-1:0] CJK_BASE_B = 21'h002010;
    localparam logic [CP_W-1:0] CJK_OFF_B  = 21'd1106;
    localparam logic [CP_W-1:0] CJK_OFF_C  = 21'd3010;
    localparam logic [CP_W-1:0] CJK_BASE_D = 21'h00FE00;
    localparam logic [CP_W-1:0] CJK_OFF_D  = 21'd3458;
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;

    // Outcome of the range decode: a fixed answer or a bit of one ROM.
    typedef struct packed {
        logic             hit_rom;
        logic             is_cjk;
        logic             const_wide;
        logic [IDX_W-1:0] bit_idx;
    } t_lookup;

    function automatic t_lookup lk_const(input logic wide);
        t_lookup lk;
        lk.hit_rom    = 1'b0;
        lk.is_cjk     = 1'b0;
        lk.const_wide = wide;
        lk.bit_idx    = '0;
        return lk;
    endfunction

    function automatic t_lookup lk_rom(input logic cjk, input logic [CP_W-1:0] idx);
        t_lookup lk;
        lk.hit_rom    = 1'b1;
        lk.is_cjk     = cjk;
        lk.const_wide = 1'b0;
        lk.bit_idx    = idx[IDX_W-1:0];
        return lk;
    endfunction

    // Bitmap for the normal rules, 29 words.
    function automatic logic [WORD_W-1:0] rom_std_word(input logic [4:0] w);
        logic [WORD_W-1:0] d;
        unique case (w)
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7,
            5'd8, 5'd9, 5'd10, 5'd11, 5'd12:     d = 32'hFFFFFFFF;
            5'd13:                               d = 32'h7FFFFFFF;
            5'd14:                               d = 32'h000003FF;
            5'd15, 5'd16:                        d = 32'hFFFFFFFF;
            5'd21:                               d = 32'hFFFF0000;
            5'd22, 5'd23:                        d = 32'hFFFFFFFF;
            5'd24:                               d = 32'h0001FFFF;
            5'd28:                               d = 32'h007F0000;
            default:                             d = 32'h00000000;
        endcase
        return d;
    endfunction

    // Bitmap for the CJK rules, 124 words.
    function automatic logic [WORD_W-1:0] rom_cjk_word(input logic [6:0] w);
        logic [WORD_W-1:0] d;
        unique case (w)
            7'd5:   d = 32'h00530180;
            7'd6:   d = 32'h00800000;
            7'd7:   d = 32'h00800400;
            7'd14:  d = 32'h1FFFE000;
            7'd15:  d = 32'h00200000;
            7'd22:  d = 32'h00000C00;
            7'd24:  d = 32'h00180000;
            7'd25:  d = 32'h00420000;
            7'd28:  d = 32'hFFFE0000;
            7'd29:  d = 32'hFFFE03FB;
            7'd30:  d = 32'h000003FB;
            7'd32:  d = 32'hFFFF0002;
            7'd33:  d = 32'hFFFFFFFF;
            7'd34:  d = 32'hCDA6FFFF;
            7'd35:  d = 32'h203403DC;
            7'd36:  d = 32'h00000001;
            7'd37:  d = 32'h00400000;
            7'd38:  d = 32'h0000007A;
            7'd39:  d = 32'h00004000;
            7'd42:  d = 32'h01000020;
            7'd43:  d = 32'h20002018;
            7'd44:  d = 32'h001C0000;
            7'd45:  d = 32'hFFFFFFFC;
            7'd46:  d = 32'h003C0FFF;
            7'd48:  d = 32'h00500000;
            7'd50:  d = 32'h90082634;
            7'd51:  d = 32'h80C17E87;
            7'd52:  d = 32'h00100000;
            7'd53:  d = 32'h0000330C;
            7'd54:  d = 32'h00000330;
            7'd55:  d = 32'h00000080;
            7'd56:  d = 32'h00000002;
            7'd58:  d = 32'h04100200;
            7'd59:  d = 32'h00001800;
            7'd69:  d = 32'hFFFFFFFC;
            7'd70, 7'd71, 7'd72: d = 32'hFFFFFFFF;
            7'd73:  d = 32'hFFFFEFFF;
            7'd74, 7'd75: d = 32'hFFFFFFFF;
            7'd76:  d = 32'hFFFC3FFF;
            7'd77:  d = 32'h0007FFFF;
            7'd78:  d = 32'hFF000000;
            7'd79:  d = 32'hC030000F;
            7'd80:  d = 32'h00032300;
            7'd81:  d = 32'h00020000;
            7'd82:  d = 32'hF3FFFFFC;
            7'd83:  d = 32'h87FFFFFF;
            7'd84:  d = 32'hFFFFFFFF;
            7'd85:  d = 32'hFFF29403;
            7'd86:  d = 32'h00000001;
            7'd87:  d = 32'h80000007;
            7'd88:  d = 32'hFFFEFFFF;
            7'd89, 7'd90, 7'd91, 7'd92: d = 32'hFFFFFFFF;
            7'd93:  d = 32'hFF0003FF;
            7'd94, 7'd95, 7'd96, 7'd97, 7'd98, 7'd99, 7'd100, 7'd101,
            7'd102, 7'd103, 7'd104, 7'd105, 7'd106,
            7'd107: d = 32'hFFFFFFFF;
            7'd108: d = 32'h0FFFFFFD;
            7'd109: d = 32'hFFFC0000;
            7'd110: d = 32'hFFFFFFFF;
            7'd111: d = 32'h0003FFFF;
            7'd116: d = 32'hFFFFFFFC;
            7'd117, 7'd118: d = 32'hFFFFFFFF;
            7'd119: d = 32'h00000007;
            7'd123: d = 32'h800001FC;
            default: d = 32'h00000000;
        endcase
        return d;
    endfunction

endpackage

/* src/wcw_classify.sv */
// Range decode: maps a code point to a fixed width or to a bit position in one bitmap ROM.
module wcw_classify (
    input  logic [20:0]       i_code_point,
    input  logic              i_cjk,
    output wcw_pkg::t_lookup  o_lookup
);
    import wcw_pkg::*;

    logic [CP_W-1:0] n;
    logic [CP_W-1:0] d_std_a;
    logic [CP_W-1:0] d_std_b;
    logic [CP_W-1:0] d_cjk_b;
    logic [CP_W-1:0] d_cjk_c;
    logic [CP_W-1:0] d_cjk_d;
    t_lookup         lk_std;
    t_lookup         lk_cjk;

    assign n = i_code_point;

    // ROM bit positions for every bitmap range, formed in parallel.
    assign d_std_a = n - STD_BASE_A;
    assign d_std_b = n - STD_BASE_B + STD_OFF_B;
    assign d_cjk_b = n - CJK_BASE_B + CJK_OFF_B;
    assign d_cjk_c = n - STD_BASE_A + CJK_OFF_C;
    assign d_cjk_d = n - CJK_BASE_D + CJK_OFF_D;

    // Normal rules: Wide and Fullwidth classes.
    always_comb begin
        priority if (n <= 21'h0010FF) lk_std = lk_const(1'b0);
        else if (n <= 21'h00115F) lk_std = lk_const(1'b1);
        else if (n <= 21'h002328) lk_std = lk_const(1'b0);
        else if (n <= 21'h00232A) lk_std = lk_const(1'b1);
        else if (n <= 21'h002E7F) lk_std = lk_const(1'b0);
        else if (n <= 21'h00303F) lk_std = lk_rom(1'b0, d_std_a);
        else if (n <= 21'h003247) lk_std = lk_const(1'b1);
        else if (n <= 21'h00324F) lk_std = lk_const(1'b0);
        else if (n <= 21'h004DBF) lk_std = lk_const(1'b1);
        else if (n <= 21'h004DFF) lk_std = lk_const(1'b0);
        else if (n <= 21'h00A4CF) lk_std = lk_const(1'b1);
        else if (n <= 21'h00A95F) lk_std = lk_const(1'b0);
        else if (n <= 21'h00A97C) lk_std = lk_const(1'b1);
        else if (n <= 21'h00ABFF) lk_std = lk_const(1'b0);
        else if (n <= 21'h00D7A3) lk_std = lk_const(1'b1);
        else if (n <= 21'h00F8FF) lk_std = lk_const(1'b0);
        else if (n <= 21'h00FAFF) lk_std = lk_const(1'b1);
        else if (n <= 21'h00FE0F) lk_std = lk_const(1'b0);
        else if (n <= 21'h00FFE6) lk_std = lk_rom(1'b0, d_std_b);
        else if (n <= 21'h01AFFF) lk_std = lk_const(1'b0);
        else if (n <= 21'h01B001) lk_std = lk_const(1'b1);
        else if (n <= 21'h01F1FF) lk_std = lk_const(1'b0);
        else if (n <= 21'h01F2FF) lk_std = lk_const(1'b1);
        else if (n <= 21'h01FFFF) lk_std = lk_const(1'b0);
        else if (n <= 21'h02FFFD) lk_std = lk_const(1'b1);
        else if (n <= 21'h02FFFF) lk_std = lk_const(1'b0);
        else if (n <= 21'h03FFFD) lk_std = lk_const(1'b1);
        else lk_std = lk_const(1'b0);
    end

    // CJK rules: ambiguous-width characters also count as wide.
    always_comb begin
        priority if (n <= 21'h000451) lk_cjk = lk_rom(1'b1, n);
        else if (n <= 21'h0010FF) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h00115F) lk_cjk = lk_const(1'b1);
        else if (n <= 21'h00200F) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h00277F) lk_cjk = lk_rom(1'b1, d_cjk_b);
        else if (n <= 21'h002B54) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h002B59) lk_cjk = lk_const(1'b1);
        else if (n <= 21'h002E7F) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h00303F) lk_cjk = lk_rom(1'b1, d_cjk_c);
        else if (n <= 21'h004DBF) lk_cjk = lk_const(1'b1);
        else if (n <= 21'h004DFF) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h00A4CF) lk_cjk = lk_const(1'b1);
        else if (n <= 21'h00A95F) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h00A97C) lk_cjk = lk_const(1'b1);
        else if (n <= 21'h00ABFF) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h00D7A3) lk_cjk = lk_const(1'b1);
        else if (n <= 21'h00DFFF) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h00FAFF) lk_cjk = lk_const(1'b1);
        else if (n <= 21'h00FDFF) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h00FFFD) lk_cjk = lk_rom(1'b1, d_cjk_d);
        else if (n <= 21'h01AFFF) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h01B001) lk_cjk = lk_const(1'b1);
        else if (n <= 21'h01F0FF) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h01F77F) lk_cjk = lk_const(1'b1);
        else if (n <= 21'h01FFFF) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h02FFFD) lk_cjk = lk_const(1'b1);
        else if (n <= 21'h02FFFF) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h03FFFD) lk_cjk = lk_const(1'b1);
        else if (n <= 21'h0E00FF) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h0E01EF) lk_cjk = lk_const(1'b1);
        else if (n <= 21'h0EFFFF) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h0FFFFD) lk_cjk = lk_const(1'b1);
        else if (n <= 21'h0FFFFF) lk_cjk = lk_const(1'b0);
        else if (n <= 21'h10FFFD) lk_cjk = lk_const(1'b1);
        else lk_cjk = lk_const(1'b0);
    end

    // Code points beyond Unicode are narrow under either rule set.
    always_comb begin
        if (n > CP_MAX) begin
            o_lookup = lk_const(1'b0);
        end else if (i_cjk) begin
            o_lookup = lk_cjk;
        end else begin
            o_lookup = lk_std;
        end
    end

endmodule

/* src/wide_char_width_classifier.sv */
// Top level: three-stage pipeline that classifies code points as wide or narrow.
// An accepted item moves through r_s1, r_s2 and r_out, which drive o_valid/o_is_wide.
// One item per cycle when not stalled; stages are range decode, bitmap ROM read, bit select.
// A stall on the output holds each stage; empty stages keep taking items until all are full.
// Reset (synchronous, active low) empties the pipeline and selects the normal width rules.
module wide_char_width_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [20:0] i_code_point,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_wide
);
    import wcw_pkg::*;

    logic              r_cjk;
    t_lookup           lk;

    logic              r_s1_valid;
    t_lookup           r_s1_lk;
    logic              r_s2_valid;
    logic              r_s2_rom;
    logic              r_s2_const;
    logic [WORD_W-1:0] r_s2_word;
    logic [SEL_W-1:0]  r_s2_sel;
    logic              r_out_valid;
    logic              r_out_wide;

    logic              rdy1;
    logic              rdy2;
    logic              rdy3;
    logic [WORD_W-1:0] n_word;

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cjk <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_cjk <= i_cfg_wr_data;
        end
    end

    // Each stage moves on when it is empty or the next stage moves on.
    assign rdy3    = !r_out_valid || !i_stall;
    assign rdy2    = !r_s2_valid || rdy3;
    assign rdy1    = !r_s1_valid || rdy2;
    assign o_stall = !rdy1;

    // Stage one: range decode of the incoming code point.
    wcw_classify u_classify (
        .i_code_point (i_code_point),
        .i_cjk        (r_cjk),
        .o_lookup     (lk)
    );

    // Stage two: read the ROM word that holds the selected bit.
    always_comb begin
        if (r_s1_lk.is_cjk) begin
            n_word = rom_cjk_word(r_s1_lk.bit_idx[IDX_W-1:SEL_W]);
        end else begin
            n_word = rom_std_word(r_s1_lk.bit_idx[SEL_W+4:SEL_W]);
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_valid <= i_valid;
            end
            if (rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (rdy3) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // Payload registers; they load only when their stage takes a new item.
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_s1_lk <= lk;
        end
        if (rdy2 && r_s1_valid) begin
            r_s2_rom   <= r_s1_lk.hit_rom;
            r_s2_const <= r_s1_lk.const_wide;
            r_s2_word  <= n_word;
            r_s2_sel   <= r_s1_lk.bit_idx[SEL_W-1:0];
        end
        if (rdy3 && r_s2_valid) begin
            r_out_wide <= r_s2_rom ? r_s2_word[r_s2_sel] : r_s2_const;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_is_wide = r_out_wide;

endmodule

/* src/wcw_checker.sv */
// Port-level checks of the width classifier and their binding to the top level.
module wcw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_wr_en,
    input logic        i_cfg_wr_data,
    input logic        i_valid,
    input logic        o_stall,
    input logic [20:0] i_code_point,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_is_wide
);

    logic acc;
    logic acc_beyond;
    logic acc_hangul;
    logic cfg_seen;

    // An item accepted outside reset, and two classes whose width never depends on the mode.
    assign acc        = i_rst_n && i_valid && !o_stall;
    assign acc_beyond = acc && (i_code_point > 21'h10FFFF);
    assign acc_hangul = acc && (i_code_point >= 21'h001100) && (i_code_point <= 21'h00115F);
    assign cfg_seen   = i_cfg_wr_en && i_cfg_wr_data;

    // A result held by a stall keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_is_wide))
        else $error("stalled result changed");

    // The pipeline is empty after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Input is held off only when every stage is full and the output is stalled.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while the pipeline had room");

    // With no output stall on the way, a code point beyond Unicode comes out narrow.
    a_beyond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(acc_beyond, 3) && $past(i_rst_n, 2) && $past(i_rst_n, 1)
            && !$past(i_stall, 2) && !$past(i_stall, 1)
        |-> o_valid && !o_is_wide)
        else $error("code point beyond Unicode not reported narrow");

    // Hangul leading jamo come out wide under either rule set.
    a_hangul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(acc_hangul, 3) && $past(i_rst_n, 2) && $past(i_rst_n, 1)
            && !$past(i_stall, 2) && !$past(i_stall, 1) && !$past(cfg_seen, 3)
        |-> o_valid && o_is_wide)
        else $error("Hangul jamo not reported wide");

endmodule

bind wide_char_width_classifier wcw_checker u_wcw_checker (.*);

/* bench/wide_char_width_classifier_tb.sv */
// Self-checking testbench for the wide character width classifier, with its own width predictor.
module wide_char_width_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wcw_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_WAIT     = 13;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int EDGE_COUNT   = 44;
    localparam int PROBE_COUNT  = 25;

    // Rule sets selected by the ambiguous-width register.
    localparam logic RULES_NORMAL = 1'b0;
    localparam logic RULES_CJK    = 1'b1;

    // One expected classification, in the order the items were accepted.
    typedef struct {
        logic [CP_W-1:0] code_point;
        logic            rules;
        logic            is_wide;
    } t_width_expect;

    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            i_cfg_wr_en   = 1'b0;
    logic            i_cfg_wr_data = 1'b0;
    logic            i_valid       = 1'b0;
    logic            o_stall;
    logic [CP_W-1:0] i_code_point  = '0;
    logic            o_valid;
    logic            i_stall       = 1'b0;
    logic            o_is_wide;

    t_width_expect pending_widths[$];
    t_width_expect oldest_width;

    logic cfg_ambiguous  = RULES_NORMAL;
    logic sender_gaps_on = 1'b1;
    logic rx_gaps_on     = 1'b1;
    logic rx_hold_req    = 1'b0;
    int   mismatches     = 0;
    int   items_sent     = 0;
    int   wide_items     = 0;
    int   cjk_items      = 0;
    int   stall_cycles   = 0;
    int   quiet_cycles   = 0;

    // Bitmap for the normal rules, one bit per code point of the looked-up ranges.
    logic [31:0] std_bitmap [0:28] = '{
        32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'hFFFFFFFF, 32'h7FFFFFFF, 32'h000003FF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'hFFFF0000, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'h0001FFFF, 32'h00000000, 32'h00000000, 32'h00000000, 32'h007F0000
    };

    // Bitmap for the CJK rules, where ambiguous characters are wide.
    logic [31:0] cjk_bitmap [0:123] = '{
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00530180,
        32'h00800000, 32'h00800400, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h1FFFE000, 32'h00200000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000C00, 32'h00000000,
        32'h00180000, 32'h00420000, 32'h00000000, 32'h00000000, 32'hFFFE0000, 32'hFFFE03FB,
        32'h000003FB, 32'h00000000, 32'hFFFF0002, 32'hFFFFFFFF, 32'hCDA6FFFF, 32'h203403DC,
        32'h00000001, 32'h00400000, 32'h0000007A, 32'h00004000, 32'h00000000, 32'h00000000,
        32'h01000020, 32'h20002018, 32'h001C0000, 32'hFFFFFFFC, 32'h003C0FFF, 32'h00000000,
        32'h00500000, 32'h00000000, 32'h90082634, 32'h80C17E87, 32'h00100000, 32'h0000330C,
        32'h00000330, 32'h00000080, 32'h00000002, 32'h00000000, 32'h04100200, 32'h00001800,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'hFFFFFFFC, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'hFFFFFFFF, 32'hFFFFEFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFC3FFF, 32'h0007FFFF,
        32'hFF000000, 32'hC030000F, 32'h00032300, 32'h00020000, 32'hF3FFFFFC, 32'h87FFFFFF,
        32'hFFFFFFFF, 32'hFFF29403, 32'h00000001, 32'h80000007, 32'hFFFEFFFF, 32'hFFFFFFFF,
        32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFF0003FF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'h0FFFFFFD, 32'hFFFC0000, 32'hFFFFFFFF, 32'h0003FFFF, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'hFFFFFFFC, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000007,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h800001FC
    };

    // Last code point of every range in both rule ladders.
    int ladder_edges [0:EDGE_COUNT-1] = '{
        'h451, 'h10FF, 'h115F, 'h200F, 'h2328, 'h232A, 'h277F, 'h2B54, 'h2B59, 'h2E7F,
        'h303F, 'h3247, 'h324F, 'h4DBF, 'h4DFF, 'hA4CF, 'hA95F, 'hA97C, 'hABFF, 'hD7A3,
        'hDFFF, 'hF8FF, 'hFAFF, 'hFDFF, 'hFE0F, 'hFFE6, 'hFFFD, 'h1AFFF, 'h1B001, 'h1F0FF,
        'h1F1FF, 'h1F2FF, 'h1F77F, 'h1FFFF, 'h2FFFD, 'h2FFFF, 'h3FFFD, 'hE00FF, 'hE01EF,
        'hEFFFF, 'hFFFFD, 'hFFFFF, 'h10FFFD, 'h10FFFF
    };

    // Field extremes, the Unicode limit, surrogates and the bitmap ranges.
    logic [CP_W-1:0] probe_points [0:PROBE_COUNT-1] = '{
        21'h000000, 21'h1FFFFF, 21'h10FFFF, 21'h110000, 21'h10FFFD, 21'h10FFFE,
        21'h0000A7, 21'h000451, 21'h000452, 21'h0010FF, 21'h001100, 21'h002010,
        21'h002E80, 21'h003000, 21'h00303F, 21'h00D800, 21'h00DFFF, 21'h00E000,
        21'h00FE10, 21'h00FF01, 21'h00FFE6, 21'h00FFFD, 21'h01F300, 21'h0E0100,
        21'h03FFFE
    };

    wide_char_width_classifier u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_code_point  (i_code_point),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_is_wide     (o_is_wide)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Bit lookups; indexes past the end of a bitmap read as narrow.
    function automatic logic std_bitmap_bit(input int idx);
        if ((idx >> 5) >= 29) return 1'b0;
        return std_bitmap[idx >> 5][idx & 31];
    endfunction

    function automatic logic cjk_bitmap_bit(input int idx);
        if ((idx >> 5) >= 124) return 1'b0;
        return cjk_bitmap[idx >> 5][idx & 31];
    endfunction

    // Normal rules: East Asian Wide and Fullwidth only.
    function automatic logic normal_rules_wide(input int n);
        if (n <= 'h10FF) return 1'b0;
        if (n <= 'h115F) return 1'b1;
        if (n <= 'h2328) return 1'b0;
        if (n <= 'h232A) return 1'b1;
        if (n <= 'h2E7F) return 1'b0;
        if (n <= 'h303F) return std_bitmap_bit(n - int'(STD_BASE_A));
        if (n <= 'h3247) return 1'b1;
        if (n <= 'h324F) return 1'b0;
        if (n <= 'h4DBF) return 1'b1;
        if (n <= 'h4DFF) return 1'b0;
        if (n <= 'hA4CF) return 1'b1;
        if (n <= 'hA95F) return 1'b0;
        if (n <= 'hA97C) return 1'b1;
        if (n <= 'hABFF) return 1'b0;
        if (n <= 'hD7A3) return 1'b1;
        if (n <= 'hF8FF) return 1'b0;
        if (n <= 'hFAFF) return 1'b1;
        if (n <= 'hFE0F) return 1'b0;
        if (n <= 'hFFE6) return std_bitmap_bit(n - int'(STD_BASE_B) + int'(STD_OFF_B));
        if (n <= 'h1AFFF) return 1'b0;
        if (n <= 'h1B001) return 1'b1;
        if (n <= 'h1F1FF) return 1'b0;
        if (n <= 'h1F2FF) return 1'b1;
        if (n <= 'h1FFFF) return 1'b0;
        if (n <= 'h2FFFD) return 1'b1;
        if (n <= 'h2FFFF) return 1'b0;
        if (n <= 'h3FFFD) return 1'b1;
        return 1'b0;
    endfunction

    // CJK rules: ambiguous-width characters count as wide as well.
    function automatic logic cjk_rules_wide(input int n);
        if (n <= 'h451) return cjk_bitmap_bit(n);
        if (n <= 'h10FF) return 1'b0;
        if (n <= 'h115F) return 1'b1;
        if (n <= 'h200F) return 1'b0;
        if (n <= 'h277F) return cjk_bitmap_bit(n - int'(CJK_BASE_B) + int'(CJK_OFF_B));
        if (n <= 'h2B54) return 1'b0;
        if (n <= 'h2B59) return 1'b1;
        if (n <= 'h2E7F) return 1'b0;
        if (n <= 'h303F) return cjk_bitmap_bit(n - int'(STD_BASE_A) + int'(CJK_OFF_C));
        if (n <= 'h4DBF) return 1'b1;
        if (n <= 'h4DFF) return 1'b0;
        if (n <= 'hA4CF) return 1'b1;
        if (n <= 'hA95F) return 1'b0;
        if (n <= 'hA97C) return 1'b1;
        if (n <= 'hABFF) return 1'b0;
        if (n <= 'hD7A3) return 1'b1;
        if (n <= 'hDFFF) return 1'b0;
        if (n <= 'hFAFF) return 1'b1;
        if (n <= 'hFDFF) return 1'b0;
        if (n <= 'hFFFD) return cjk_bitmap_bit(n - int'(CJK_BASE_D) + int'(CJK_OFF_D));
        if (n <= 'h1AFFF) return 1'b0;
        if (n <= 'h1B001) return 1'b1;
        if (n <= 'h1F0FF) return 1'b0;
        if (n <= 'h1F77F) return 1'b1;
        if (n <= 'h1FFFF) return 1'b0;
        if (n <= 'h2FFFD) return 1'b1;
        if (n <= 'h2FFFF) return 1'b0;
        if (n <= 'h3FFFD) return 1'b1;
        if (n <= 'hE00FF) return 1'b0;
        if (n <= 'hE01EF) return 1'b1;
        if (n <= 'hEFFFF) return 1'b0;
        if (n <= 'hFFFFD) return 1'b1;
        if (n <= 'hFFFFF) return 1'b0;
        if (n <= 'h10FFFD) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic predict_wide(input logic [CP_W-1:0] cp, input logic rules);
        if (cp > CP_MAX) return 1'b0;
        if (rules == RULES_CJK) return cjk_rules_wide(int'(cp));
        return normal_rules_wide(int'(cp));
    endfunction

    // Random code points weighted toward range edges and bitmap ranges.
    function automatic logic [CP_W-1:0] pick_code_point();
        int unsigned v;
        int unsigned lo;
        int unsigned hi;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                v = ladder_edges[$urandom_range(0, EDGE_COUNT - 1)] - 1 + $urandom_range(0, 3);
            end
            4, 5: begin
                case ($urandom_range(0, 4))
                    0: begin lo = 'h2E80; hi = 'h303F; end
                    1: begin lo = 'hFE10; hi = 'hFFE6; end
                    2: begin lo = 'h0000; hi = 'h0451; end
                    3: begin lo = 'h2010; hi = 'h277F; end
                    default: begin lo = 'hFE00; hi = 'hFFFD; end
                endcase
                v = lo + $urandom_range(0, hi - lo);
            end
            6: v = $urandom_range(0, 'hFFFF);
            7: v = $urandom_range(0, 'h10FFFF);
            8: v = $urandom() & 'h1FFFFF;
            default: v = $urandom_range('h110000, 'h1FFFFF);
        endcase
        return v[CP_W-1:0];
    endfunction

    // Offer one code point, hold it until accepted, and record its expected width.
    task automatic send_code_point(input logic [CP_W-1:0] cp);
        int gap;
        t_width_expect item;
        gap = sender_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            @(negedge i_clk) i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_code_point <= cp;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        item.code_point = cp;
        item.rules      = cfg_ambiguous;
        item.is_wide    = predict_wide(cp, cfg_ambiguous);
        pending_widths.push_back(item);
        items_sent++;
        if (item.is_wide) wide_items++;
        if (cfg_ambiguous == RULES_CJK) cjk_items++;
    endtask

    task automatic stop_items();
        @(negedge i_clk) i_valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (pending_widths.size() != 0) @(posedge i_clk);
    endtask

    // Register writes happen only with the pipeline empty.
    task automatic set_ambiguous_wide(input logic rules);
        wait_results_drained();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= rules;
        @(posedge i_clk) cfg_ambiguous = rules;
        @(negedge i_clk) i_cfg_wr_en <= 1'b0;
    endtask

    task automatic test_range_edges(input logic rules);
        set_ambiguous_wide(rules);
        sender_gaps_on = 1'b1;
        rx_gaps_on     = 1'b1;
        for (int k = 0; k < PROBE_COUNT; k++) send_code_point(probe_points[k]);
        stop_items();
    endtask

    task automatic test_random_mix(input logic rules, input int count, input logic idling);
        set_ambiguous_wide(rules);
        sender_gaps_on = idling;
        rx_gaps_on     = idling;
        repeat (count) send_code_point(pick_code_point());
        stop_items();
    endtask

    // The receiver holds off while items keep coming, so the pipeline fills and stalls.
    task automatic test_output_backpressure();
        sender_gaps_on = 1'b0;
        rx_gaps_on     = 1'b1;
        rx_hold_req    = 1'b1;
        repeat (40) send_code_point(pick_code_point());
        stop_items();
        sender_gaps_on = 1'b1;
    endtask

    // After every eighth item the sender pauses until every outstanding result has come back.
    task automatic test_drain_pauses();
        set_ambiguous_wide(RULES_NORMAL);
        for (int k = 0; k < 40; k++) begin
            send_code_point(pick_code_point());
            if (k % 8 == 7) begin
                stop_items();
                wait_results_drained();
            end
        end
        stop_items();
    endtask

    // Receiver: a random stall before each result, or one long hold-off on request.
    initial begin
        int n;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                n = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else begin
                n = rx_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (n > 0) begin
                @(negedge i_clk) i_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_widths.size() == 0) begin
                $display("%0t: unexpected result, is_wide %0b with nothing pending",
                         $time, o_is_wide);
                mismatches++;
            end else begin
                oldest_width = pending_widths.pop_front();
                if (o_is_wide !== oldest_width.is_wide) begin
                    $display("%0t: code point %06h rules %0b: expected is_wide %0b, got %0b",
                             $time, oldest_width.code_point, oldest_width.rules,
                             oldest_width.is_wide, o_is_wide);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item; also counts input stalls.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_stall) stall_cycles++;
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("wide_char_width_classifier_tb failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_range_edges(RULES_NORMAL);
        test_range_edges(RULES_CJK);
        for (int k = 0; k < 6; k++) begin
            test_random_mix((k % 2) ? RULES_CJK : RULES_NORMAL, 100, (k % 3) != 2);
        end
        test_output_backpressure();
        test_drain_pauses();

        wait_results_drained();
        repeat (10) @(posedge i_clk);
        $display("Classified %0d code points (%0d under CJK rules), %0d of them wide.",
                 items_sent, cjk_items, wide_items);
        $display("Input was stalled for %0d cycles; %0d mismatches seen.",
                 stall_cycles, mismatches);
        if (mismatches == 0 && pending_widths.size() == 0) begin
            $display("wide_char_width_classifier_tb passed");
        end else begin
            $display("wide_char_width_classifier_tb failed");
        end
        $finish;
    end

endmodule

/* sim.f */
src/wcw_pkg.sv
src/wcw_classify.sv
src/wide_char_width_classifier.sv
src/wcw_checker.sv
bench/wide_char_width_classifier_tb.sv
